/* rtl/gras_pkg.sv */
package gras_pkg;

	localparam int unsigned CHANNELS  = 2;
	localparam int unsigned VOLT_W    = 32;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned CFG_IDX_W = 4;

	typedef logic [1:0] gain_t;

	localparam gain_t GAIN_LOW     = 2'd0;
	localparam gain_t GAIN_MID     = 2'd1;
	localparam gain_t GAIN_HIGH    = 2'd2;
	localparam gain_t GAIN_INVALID = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SWITCH_MODE   = 4'd0;
	localparam cfg_idx_t REG_COUNT_THR     = 4'd1;
	localparam cfg_idx_t REG_UPPER_NB      = 4'd2;
	localparam cfg_idx_t REG_UPPER_WB      = 4'd3;
	localparam cfg_idx_t REG_LOWER_MID_NB  = 4'd4;
	localparam cfg_idx_t REG_LOWER_MID_WB  = 4'd5;
	localparam cfg_idx_t REG_LOWER_HIGH_NB = 4'd6;
	localparam cfg_idx_t REG_LOWER_HIGH_WB = 4'd7;

	typedef struct packed {
		gain_t            gain;
		logic [CNT_W-1:0] up_low;
		logic [CNT_W-1:0] up_mid;
		logic [CNT_W-1:0] dn_mid;
		logic [CNT_W-1:0] dn_high;
	} ch_state_t;

	typedef struct packed {
		logic              cmd_mode;
		logic [CNT_W-1:0]  count_thr;
		logic [VOLT_W-1:0] upper;
		logic [VOLT_W-1:0] lower_mid;
		logic [VOLT_W-1:0] lower_high;
	} ch_cfg_t;

endpackage

/* rtl/gras_step.sv */
module gras_step (
	input  gras_pkg::ch_cfg_t          cfg,
	input  gras_pkg::ch_state_t        cur,
	input  logic [gras_pkg::VOLT_W-1:0] voltage,
	input  gras_pkg::gain_t            gain_code,
	output gras_pkg::ch_state_t        nxt,
	output logic                       changed
);

	typedef enum logic [2:0] {
		Q_NONE,
		Q_UP_LOW,
		Q_UP_MID,
		Q_DN_MID,
		Q_DN_HIGH
	} qual_t;

	qual_t                       qual;
	logic [gras_pkg::CNT_W-1:0]  sel_cnt;
	logic [gras_pkg::CNT_W-1:0]  bumped;
	logic                        hit;
	logic                        above;
	logic                        below_mid;
	logic                        below_high;

	assign above      = voltage > cfg.upper;
	assign below_mid  = voltage < cfg.lower_mid;
	assign below_high = voltage < cfg.lower_high;

	always_comb begin
		qual = Q_NONE;
		case (gain_code)
			gras_pkg::GAIN_LOW: begin
				if (above) qual = Q_UP_LOW;
			end
			gras_pkg::GAIN_MID: begin
				if (above) qual = Q_UP_MID;
				else if (below_mid) qual = Q_DN_MID;
			end
			gras_pkg::GAIN_HIGH: begin
				if (below_high) qual = Q_DN_HIGH;
			end
			default: qual = Q_NONE;
		endcase
	end

	always_comb begin
		case (qual)
			Q_UP_LOW:  sel_cnt = cur.up_low;
			Q_UP_MID:  sel_cnt = cur.up_mid;
			Q_DN_MID:  sel_cnt = cur.dn_mid;
			Q_DN_HIGH: sel_cnt = cur.dn_high;
			default:   sel_cnt = '0;
		endcase
	end

	// saturating increment
	assign bumped = (&sel_cnt) ? sel_cnt : sel_cnt + 1'b1;
	assign hit    = bumped >= cfg.count_thr;

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		if (cfg.cmd_mode) begin
			nxt.gain = gain_code;
			changed  = 1'b1;
		end else if (qual != Q_NONE) begin
			nxt.up_low  = '0;
			nxt.up_mid  = '0;
			nxt.dn_mid  = '0;
			nxt.dn_high = '0;
			changed     = hit;
			case (qual)
				Q_UP_LOW: begin
					if (hit) nxt.gain = gras_pkg::GAIN_MID;
					else nxt.up_low = bumped;
				end
				Q_UP_MID: begin
					if (hit) nxt.gain = gras_pkg::GAIN_HIGH;
					else nxt.up_mid = bumped;
				end
				Q_DN_MID: begin
					if (hit) nxt.gain = gras_pkg::GAIN_LOW;
					else nxt.dn_mid = bumped;
				end
				Q_DN_HIGH: begin
					if (hit) nxt.gain = gras_pkg::GAIN_MID;
					else nxt.dn_high = bumped;
				end
				default: nxt = cur;
			endcase
		end
	end

endmodule

/* rtl/gain_range_autoswitch_core.sv */
// Gain range auto-switch for two sensor channels.
// Path: input register, then result register. Throughput: 1 beat per cycle when out_ready
// does not stall the result register; per-channel state updates in the same cycle the
// result register loads, so back-to-back beats on one channel see fresh state.
// Reset (arst_n low, async): gains to high, counters cleared, registers to defaults.
module gain_range_autoswitch_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     channel,
	input  logic [gras_pkg::VOLT_W-1:0]    voltage,
	input  logic [1:0]                     gain_code,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     out_channel,
	output logic [1:0]                     current_gain,
	output logic                           gain_changed,
	output logic                           accepted,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gras_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int unsigned CH_W = (gras_pkg::CHANNELS > 1) ? $clog2(gras_pkg::CHANNELS) : 1;

	logic                            mode_q;
	logic [gras_pkg::CNT_W-1:0]      count_thr_q;
	logic [gras_pkg::VOLT_W-1:0]     upper_q      [gras_pkg::CHANNELS];
	logic [gras_pkg::VOLT_W-1:0]     lower_mid_q  [gras_pkg::CHANNELS];
	logic [gras_pkg::VOLT_W-1:0]     lower_high_q [gras_pkg::CHANNELS];

	gras_pkg::ch_state_t             state_q [gras_pkg::CHANNELS];

	logic                            valid_s1;
	logic [1:0]                      channel_s1;
	logic [gras_pkg::VOLT_W-1:0]     voltage_s1;
	gras_pkg::gain_t                 gain_s1;

	logic                            advance;
	logic                            item_ok;
	logic [CH_W-1:0]                 ch_idx;
	gras_pkg::ch_cfg_t               ch_cfg;
	gras_pkg::ch_state_t             cur_state;
	gras_pkg::ch_state_t             nxt_state;
	logic                            step_changed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= 1'b0;
			count_thr_q     <= gras_pkg::CNT_W'(1);
			upper_q[0]      <= '0;
			upper_q[1]      <= '0;
			lower_mid_q[0]  <= '0;
			lower_mid_q[1]  <= '0;
			lower_high_q[0] <= '0;
			lower_high_q[1] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gras_pkg::REG_SWITCH_MODE:   mode_q          <= cfg_data[0];
				gras_pkg::REG_COUNT_THR:     count_thr_q     <= cfg_data[gras_pkg::CNT_W-1:0];
				gras_pkg::REG_UPPER_NB:      upper_q[0]      <= cfg_data;
				gras_pkg::REG_UPPER_WB:      upper_q[1]      <= cfg_data;
				gras_pkg::REG_LOWER_MID_NB:  lower_mid_q[0]  <= cfg_data;
				gras_pkg::REG_LOWER_MID_WB:  lower_mid_q[1]  <= cfg_data;
				gras_pkg::REG_LOWER_HIGH_NB: lower_high_q[0] <= cfg_data;
				gras_pkg::REG_LOWER_HIGH_WB: lower_high_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			channel_s1 <= channel;
			voltage_s1 <= voltage;
			gain_s1    <= gain_code;
		end
	end

	assign item_ok = (32'(channel_s1) < gras_pkg::CHANNELS) &&
		(gain_s1 <= gras_pkg::GAIN_HIGH);
	assign ch_idx  = channel_s1[CH_W-1:0];

	always_comb begin
		ch_cfg.cmd_mode   = mode_q;
		ch_cfg.count_thr  = count_thr_q;
		ch_cfg.upper      = upper_q[ch_idx];
		ch_cfg.lower_mid  = lower_mid_q[ch_idx];
		ch_cfg.lower_high = lower_high_q[ch_idx];
	end

	assign cur_state = state_q[ch_idx];

	gras_step u_step (
		.cfg       (ch_cfg),
		.cur       (cur_state),
		.voltage   (voltage_s1),
		.gain_code (gain_s1),
		.nxt       (nxt_state),
		.changed   (step_changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gras_pkg::CHANNELS; i++) begin
				state_q[i].gain    <= gras_pkg::GAIN_HIGH;
				state_q[i].up_low  <= '0;
				state_q[i].up_mid  <= '0;
				state_q[i].dn_mid  <= '0;
				state_q[i].dn_high <= '0;
			end
		end else if (advance && item_ok) begin
			state_q[ch_idx] <= nxt_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_channel  <= channel_s1;
			current_gain <= item_ok ? nxt_state.gain : gras_pkg::GAIN_LOW;
			gain_changed <= item_ok && step_changed;
			accepted     <= item_ok;
		end
	end

`ifndef NO_ASSERTIONS
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> current_gain == gras_pkg::GAIN_LOW && !gain_changed)
		else $error("rejected beat carries gain or change flag");

	a_gain_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> current_gain != gras_pkg::GAIN_INVALID)
		else $error("illegal gain reported");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q[0].gain != gras_pkg::GAIN_INVALID &&
		state_q[gras_pkg::CHANNELS-1].gain != gras_pkg::GAIN_INVALID)
		else $error("stored gain illegal");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !advance)
		else $error("result register overwritten while stalled");

	a_auto_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_ok && !mode_q && step_changed |->
			nxt_state.gain != cur_state.gain || nxt_state.gain != gain_s1)
		else $error("auto switch reported change without step");
`endif

endmodule

/* test/gain_range_autoswitch_core_tb.sv */
module gain_range_autoswitch_core_tb;

	localparam int N_CH          = 2;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 125;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_AFTER    = 500;
	localparam int HOLD_CYCLES   = 150;

	localparam logic [1:0] CH_NB   = 2'd0;
	localparam logic [1:0] CH_WB   = 2'd1;
	localparam logic [1:0] CH_BAD2 = 2'd2;
	localparam logic [1:0] CH_BAD3 = 2'd3;
	localparam gras_pkg::gain_t    GAIN_BAD = gras_pkg::GAIN_INVALID;
	localparam gras_pkg::cfg_idx_t REG_OUT_OF_RANGE = 4'd12;
	localparam logic [31:0] VOLT_MAX = 32'hFFFF_FFFF;

	typedef enum int {CTR_UP_LOW, CTR_UP_MID, CTR_DN_MID, CTR_DN_HIGH} ctr_sel_t;
	typedef enum int {GO_UP, GO_DOWN, STAY} drift_t;

	typedef struct packed {
		logic [1:0]      chan;
		logic [31:0]     volt;
		gras_pkg::gain_t gain;
	} sample_t;

	typedef struct packed {
		logic [1:0]      chan;
		gras_pkg::gain_t gain;
		logic            changed;
		logic            acc;
	} range_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [1:0]                     channel = '0;
	logic [gras_pkg::VOLT_W-1:0]    voltage = '0;
	logic [1:0]                     gain_code = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     out_channel;
	logic [1:0]                     current_gain;
	logic                           gain_changed;
	logic                           accepted;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [gras_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                    cfg_data = '0;

	// predictor copy of config and per-channel state
	logic            cmd_mode;
	logic [15:0]     count_thr;
	logic [31:0]     upper_v[N_CH];
	logic [31:0]     lower_mid_v[N_CH];
	logic [31:0]     lower_high_v[N_CH];
	gras_pkg::gain_t gain_now[N_CH];
	logic [15:0]     range_cnt[N_CH][4];

	sample_t       pending_samples[$];
	range_result_t expected_ranges[$];
	sample_t       in_flight;
	int            samples_queued = 0;
	int            samples_taken = 0;
	int            results_seen = 0;
	int            errors = 0;
	int            send_gap = 0;
	int            recv_gap = 0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	logic          send_burst = 1'b0;
	logic          recv_burst = 1'b0;
	logic          hold_done = 1'b0;

	gain_range_autoswitch_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit count_qualifying(int ch, ctr_sel_t sel);
		logic [15:0] c;
		int k;
		c = (range_cnt[ch][sel] == 16'hFFFF) ? 16'hFFFF : range_cnt[ch][sel] + 16'd1;
		for (k = 0; k < 4; k++)
			range_cnt[ch][k] = '0;
		if (c >= count_thr)
			return 1'b1;
		range_cnt[ch][sel] = c;
		return 1'b0;
	endfunction

	function automatic range_result_t predict_range(sample_t s);
		range_result_t r;
		int ch;
		r.chan    = s.chan;
		r.gain    = gras_pkg::GAIN_LOW;
		r.changed = 1'b0;
		r.acc     = 1'b0;
		if (s.chan >= N_CH || s.gain > gras_pkg::GAIN_HIGH)
			return r;
		ch = s.chan;
		if (cmd_mode) begin
			gain_now[ch] = s.gain;
			r.changed = 1'b1;
		end else begin
			case (s.gain)
				gras_pkg::GAIN_LOW: begin
					if (s.volt > upper_v[ch]) begin
						if (count_qualifying(ch, CTR_UP_LOW)) begin
							gain_now[ch] = gras_pkg::GAIN_MID;
							r.changed = 1'b1;
						end
					end
				end
				gras_pkg::GAIN_MID: begin
					if (s.volt > upper_v[ch]) begin
						if (count_qualifying(ch, CTR_UP_MID)) begin
							gain_now[ch] = gras_pkg::GAIN_HIGH;
							r.changed = 1'b1;
						end
					end else if (s.volt < lower_mid_v[ch]) begin
						if (count_qualifying(ch, CTR_DN_MID)) begin
							gain_now[ch] = gras_pkg::GAIN_LOW;
							r.changed = 1'b1;
						end
					end
				end
				default: begin
					if (s.volt < lower_high_v[ch]) begin
						if (count_qualifying(ch, CTR_DN_HIGH)) begin
							gain_now[ch] = gras_pkg::GAIN_MID;
							r.changed = 1'b1;
						end
					end
				end
			endcase
		end
		r.gain = gain_now[ch];
		r.acc  = 1'b1;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic logic [31:0] draw_level(logic [31:0] ceiling);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VOLT_MAX;
			default: return $urandom_range(ceiling, 0);
		endcase
	endfunction

	function automatic logic [31:0] volt_in_region(logic [1:0] ch, gras_pkg::gain_t g,
			drift_t dir);
		logic [31:0] up;
		logic [31:0] low;
		up  = upper_v[ch];
		low = (g == gras_pkg::GAIN_MID) ? lower_mid_v[ch] : lower_high_v[ch];
		case (dir)
			GO_UP: begin
				if (up != VOLT_MAX)
					return $urandom_range(0, 1) ? up + 32'd1 : $urandom_range(VOLT_MAX, up + 32'd1);
			end
			GO_DOWN: begin
				if (low != '0)
					return $urandom_range(0, 1) ? low - 32'd1 : $urandom_range(low - 32'd1, 0);
			end
			default: begin
				if (g == gras_pkg::GAIN_LOW)
					return $urandom_range(0, 1) ? up : $urandom_range(up, 0);
				if (g == gras_pkg::GAIN_HIGH)
					return $urandom_range(0, 1) ? low : $urandom_range(VOLT_MAX, low);
				if (low <= up)
					return $urandom_range(0, 1) ? low : $urandom_range(up, low);
			end
		endcase
		return $urandom;
	endfunction

	task automatic queue_sample(logic [1:0] ch, logic [31:0] v, gras_pkg::gain_t g);
		sample_t s;
		s.chan = ch;
		s.volt = v;
		s.gain = g;
		pending_samples.push_back(s);
		samples_queued++;
	endtask

	// a run of same-channel, same-gain samples pushing one way or holding in range, with some noise
	task automatic queue_run();
		logic [1:0]      ch;
		gras_pkg::gain_t g;
		drift_t          dir;
		int              len;
		ch = 2'($urandom_range(0, 1));
		g  = gras_pkg::gain_t'($urandom_range(0, 2));
		case (g)
			gras_pkg::GAIN_LOW: dir = ($urandom_range(0, 3) == 0) ? STAY : GO_UP;
			gras_pkg::GAIN_MID: dir = drift_t'($urandom_range(0, 2));
			default:            dir = ($urandom_range(0, 3) == 0) ? STAY : GO_DOWN;
		endcase
		len = (count_thr <= 12) ? count_thr + $urandom_range(0, 2) : $urandom_range(1, 6);
		if (len == 0)
			len = 1;
		repeat (len) begin
			if ($urandom_range(0, 9) == 0)
				queue_sample(2'($urandom_range(0, 3)), $urandom,
					gras_pkg::gain_t'($urandom_range(0, 3)));
			else
				queue_sample(ch, volt_in_region(ch, g, dir), g);
		end
	endtask

	task automatic write_reg(gras_pkg::cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gras_pkg::REG_SWITCH_MODE:   cmd_mode = value[0];
			gras_pkg::REG_COUNT_THR:     count_thr = value[15:0];
			gras_pkg::REG_UPPER_NB:      upper_v[0] = value;
			gras_pkg::REG_UPPER_WB:      upper_v[1] = value;
			gras_pkg::REG_LOWER_MID_NB:  lower_mid_v[0] = value;
			gras_pkg::REG_LOWER_MID_WB:  lower_mid_v[1] = value;
			gras_pkg::REG_LOWER_HIGH_NB: lower_high_v[0] = value;
			gras_pkg::REG_LOWER_HIGH_WB: lower_high_v[1] = value;
			default: ;
		endcase
	endtask

	task automatic program_ranges(logic mode, logic [15:0] thr,
			logic [31:0] up_nb, logic [31:0] up_wb, logic [31:0] lm_nb,
			logic [31:0] lm_wb, logic [31:0] lh_nb, logic [31:0] lh_wb);
		write_reg(gras_pkg::REG_SWITCH_MODE, {31'd0, mode});
		write_reg(gras_pkg::REG_COUNT_THR, {16'd0, thr});
		write_reg(gras_pkg::REG_UPPER_NB, up_nb);
		write_reg(gras_pkg::REG_UPPER_WB, up_wb);
		write_reg(gras_pkg::REG_LOWER_MID_NB, lm_nb);
		write_reg(gras_pkg::REG_LOWER_MID_WB, lm_wb);
		write_reg(gras_pkg::REG_LOWER_HIGH_NB, lh_nb);
		write_reg(gras_pkg::REG_LOWER_HIGH_WB, lh_wb);
	endtask

	task automatic wait_drained();
		while (samples_taken != samples_queued || expected_ranges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : send_side
		logic offer;
		if (arst_n) begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				expected_ranges.push_back(predict_range(in_flight));
				samples_taken++;
				offer = 1'b0;
				send_gap = send_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 31) == 0)
					send_burst = !send_burst;
			end
			if (!offer) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_samples.size() != 0) begin
					in_flight = pending_samples.pop_front();
					offer = 1'b1;
					channel   <= in_flight.chan;
					voltage   <= in_flight.volt;
					gain_code <= in_flight.gain;
				end
			end
			in_valid <= offer;
		end
	end

	always @(posedge clk) begin : receive_side
		range_result_t want;
		logic rdy;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_ranges.size() == 0) begin
					$display("%0t: unexpected beat, ch %0d gain %0d changed %0b accepted %0b",
						$time, out_channel, current_gain, gain_changed, accepted);
					errors++;
				end else begin
					want = expected_ranges.pop_front();
					check_field("out_channel", int'(want.chan), int'(out_channel));
					check_field("current_gain", int'(want.gain), int'(current_gain));
					check_field("gain_changed", int'(want.changed), int'(gain_changed));
					check_field("accepted", int'(want.acc), int'(accepted));
				end
				recv_gap = recv_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 31) == 0)
					recv_burst = !recv_burst;
				// long back-pressure while the sender keeps going
				if (!hold_done && results_seen >= HOLD_AFTER && pending_samples.size() > 16) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int ch;
		int phase;
		int phase_start;
		logic        mode;
		logic [15:0] thr;
		logic [31:0] up0, up1, lm0, lm1, lh0, lh1;

		cmd_mode  = 1'b0;
		count_thr = 16'd1;
		for (ch = 0; ch < N_CH; ch++) begin
			upper_v[ch]      = '0;
			lower_mid_v[ch]  = '0;
			lower_high_v[ch] = '0;
			gain_now[ch]     = gras_pkg::GAIN_HIGH;
			for (int k = 0; k < 4; k++)
				range_cnt[ch][k] = '0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: all thresholds zero, one sample per change
		queue_sample(CH_NB, 32'd0, gras_pkg::GAIN_HIGH);
		queue_sample(CH_WB, VOLT_MAX, gras_pkg::GAIN_LOW);
		queue_sample(CH_NB, 32'd1, gras_pkg::GAIN_MID);
		queue_sample(CH_BAD2, 32'd5, gras_pkg::GAIN_LOW);
		queue_sample(CH_BAD3, VOLT_MAX, GAIN_BAD);
		queue_sample(CH_NB, 32'd7, GAIN_BAD);
		queue_sample(CH_WB, 32'd0, gras_pkg::GAIN_MID);
		wait_drained();

		program_ranges(1'b0, 16'd0, 32'd1000, 32'hFFFF_FFFE, 32'd100, 32'd1,
			32'd500, VOLT_MAX);
		write_reg(REG_OUT_OF_RANGE, VOLT_MAX);
		queue_sample(CH_NB, 32'd499, gras_pkg::GAIN_HIGH);
		queue_sample(CH_NB, 32'd500, gras_pkg::GAIN_HIGH);
		queue_sample(CH_NB, 32'd99, gras_pkg::GAIN_MID);
		queue_sample(CH_NB, 32'd1000, gras_pkg::GAIN_LOW);
		queue_sample(CH_NB, 32'd1001, gras_pkg::GAIN_LOW);
		queue_sample(CH_WB, VOLT_MAX, gras_pkg::GAIN_LOW);
		queue_sample(CH_WB, 32'hFFFF_FFFE, gras_pkg::GAIN_MID);
		queue_sample(CH_WB, 32'd0, gras_pkg::GAIN_MID);
		queue_sample(CH_WB, 32'hFFFF_FFFE, gras_pkg::GAIN_HIGH);
		wait_drained();

		// command mode: written even when unchanged
		write_reg(gras_pkg::REG_SWITCH_MODE, 32'd1);
		queue_sample(CH_NB, 32'd0, gras_pkg::GAIN_LOW);
		queue_sample(CH_NB, VOLT_MAX, gras_pkg::GAIN_MID);
		queue_sample(CH_NB, 32'd3, gras_pkg::GAIN_HIGH);
		queue_sample(CH_NB, 32'd3, gras_pkg::GAIN_HIGH);
		queue_sample(CH_NB, 32'd3, GAIN_BAD);
		queue_sample(CH_BAD2, 32'd3, gras_pkg::GAIN_MID);
		wait_drained();

		write_reg(gras_pkg::REG_SWITCH_MODE, 32'd0);
		write_reg(gras_pkg::REG_COUNT_THR, 32'h0000_FFFF);
		queue_sample(CH_NB, 32'd0, gras_pkg::GAIN_HIGH);
		queue_sample(CH_NB, 32'd2000, gras_pkg::GAIN_LOW);
		wait_drained();

		for (phase = 0; phase < PHASES; phase++) begin
			mode = (phase == 3 || phase == 6);
			case (phase)
				1: thr = 16'd0;
				2: thr = 16'($urandom_range(2, 5));
				4: thr = 16'($urandom_range(6, 12));
				7: thr = 16'hFFFF;
				8: thr = 16'($urandom);
				default: thr = 16'($urandom_range(1, 4));
			endcase
			up0 = draw_level(VOLT_MAX);
			up1 = draw_level(VOLT_MAX);
			lm0 = draw_level(up0);
			lm1 = draw_level(up1);
			lh0 = draw_level(up0);
			lh1 = draw_level(up1);
			if (phase == 5) begin
				up0 = '0;
				up1 = VOLT_MAX;
				lm0 = VOLT_MAX;
				lm1 = '0;
				lh0 = '0;
				lh1 = VOLT_MAX;
			end
			program_ranges(mode, thr, up0, up1, lm0, lm1, lh0, lh1);
			phase_start = samples_queued;
			while (samples_queued - phase_start < PHASE_ITEMS)
				queue_run();
			wait_drained();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
